### rtl/xfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// X-PAD field demultiplexer package
// Beat and result types, application type codes and the subfield length table.
// ----------------------------------------------------------------------------
package xfd_pkg;

    localparam int MAX_INDICATORS = 4;
    localparam int IND_IDX_W      = $clog2(MAX_INDICATORS);
    localparam int IND_CNT_W      = $clog2(MAX_INDICATORS + 1);

    // Application types
    localparam logic [4:0] APP_LENGTH     = 5'd1;
    localparam logic [4:0] APP_LABEL      = 5'd2;
    localparam logic [4:0] APP_LABEL_CONT = 5'd3;
    localparam logic [4:0] APP_MOT_START  = 5'd12;
    localparam logic [4:0] APP_MOT_CONT   = 5'd13;

    // F-PAD codes
    localparam logic [1:0] FPAD_TYPE_0     = 2'd0;
    localparam logic [1:0] XPAD_IND_VAR    = 2'd2;
    localparam logic [5:0] LEN_SUB_BYTES   = 6'd4;

    typedef struct packed {
        logic [7:0] pad_byte;
        logic       field_start;
        logic [7:0] field_bytes;
        logic [7:0] fpad_high;
        logic [7:0] fpad_low;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [4:0]  app_type;
        logic        sub_first;
        logic        sub_last;
        logic        without_ci;
        logic [13:0] group_length;
        logic        length_strobe;
    } result_t;

    // Subfield length from the three high bits of a contents indicator
    function automatic logic [5:0] sub_len(input logic [2:0] code);
        logic [5:0] len;
        unique case (code)
            3'd0:    len = 6'd4;
            3'd1:    len = 6'd6;
            3'd2:    len = 6'd8;
            3'd3:    len = 6'd12;
            3'd4:    len = 6'd16;
            3'd5:    len = 6'd24;
            3'd6:    len = 6'd32;
            default: len = 6'd48;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

### rtl/xfd_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// X-PAD field demultiplexer input stage
// Registers one input beat and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module xfd_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire xfd_pkg::in_beat_t beat_in,
    input  wire logic             take,
    output logic                  held_valid,
    output xfd_pkg::in_beat_t     held_beat
);
    import xfd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;
    logic     accept;

    assign in_stall   = valid_reg && !take;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= beat_in;
        end
    end

    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

endmodule
`default_nettype wire

### rtl/xfd_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// X-PAD field demultiplexer engine
// Field state, indicator table and the result for the beat being taken.
// ----------------------------------------------------------------------------
module xfd_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire xfd_pkg::in_beat_t beat,
    output logic                   emit,
    output xfd_pkg::result_t       res
);
    import xfd_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_IND, PH_CONT, PH_REPLAY} phase_t;

    phase_t               phase_reg,      phase_next;
    logic [7:0]           field_len_reg,  field_len_next;
    logic [7:0]           field_pos_reg,  field_pos_next;
    logic [IND_CNT_W-1:0] ind_count_reg,  ind_count_next;
    logic [IND_IDX_W-1:0] ind_pos_reg,    ind_pos_next;
    logic [5:0]           sub_count_reg,  sub_count_next;
    logic [7:0]           stored_len_reg, stored_len_next;
    logic [7:0]           len_acc_reg,    len_acc_next;
    logic [4:0]           prev_type_reg,  prev_type_next;
    logic [13:0]          group_len_reg,  group_len_next;
    logic [5:0]           len_high_reg,   len_high_next;
    logic                 group_open_reg, group_open_next;

    logic [7:0] ind_table [MAX_INDICATORS];
    logic       tbl_we;

    always_comb
    begin
        logic                 active;
        logic                 lab;
        logic                 mot;
        logic [7:0]           ind;
        logic [4:0]           t;
        logic [5:0]           len;
        logic                 last;
        logic [IND_CNT_W-1:0] cnt_inc;
        logic [7:0]           acc_inc;
        logic [7:0]           pos_inc;

        phase_next      = phase_reg;
        field_len_next  = field_len_reg;
        field_pos_next  = field_pos_reg;
        ind_count_next  = ind_count_reg;
        ind_pos_next    = ind_pos_reg;
        sub_count_next  = sub_count_reg;
        stored_len_next = stored_len_reg;
        len_acc_next    = len_acc_reg;
        prev_type_next  = prev_type_reg;
        group_len_next  = group_len_reg;
        len_high_next   = len_high_reg;
        group_open_next = group_open_reg;
        tbl_we          = 1'b0;
        emit            = 1'b0;
        res             = '0;
        active          = 1'b1;

        lab = (prev_type_reg == APP_LABEL) || (prev_type_reg == APP_LABEL_CONT);
        mot = ((prev_type_reg == APP_MOT_START) || (prev_type_reg == APP_MOT_CONT))
              && group_open_reg;

        ind     = ind_table[ind_pos_reg];
        t       = ind[4:0];
        len     = sub_len(ind[7:5]);
        cnt_inc = ind_count_reg + 1'b1;
        acc_inc = len_acc_reg + {2'b00, sub_len(beat.pad_byte[7:5])};
        last    = 1'b0;
        pos_inc = 8'd0;

        if (beat.field_start)
        begin
            field_len_next = beat.field_bytes;
            field_pos_next = '0;
            phase_next     = PH_IDLE;
            if (beat.field_bytes == 8'd0 || beat.fpad_high[7:6] != FPAD_TYPE_0
                || beat.fpad_high[5:4] != XPAD_IND_VAR)
            begin
                active = 1'b0;
            end
            else if (beat.fpad_low[1])
            begin
                ind_count_next = '0;
                len_acc_next   = '0;
                phase_next     = PH_IND;
            end
            else if (stored_len_reg != 8'd0 && beat.field_bytes >= stored_len_reg
                     && (lab || mot))
            begin
                phase_next = PH_REPLAY;
            end
            else
            begin
                active = 1'b0;
            end
        end

        if (phase_next == PH_IDLE)
        begin
            active = 1'b0;
        end

        if (active)
        begin
            unique case (phase_next)
                PH_IND:
                begin
                    // A fresh field restarts the count and sum
                    if (beat.field_start)
                    begin
                        cnt_inc = IND_CNT_W'(1);
                        acc_inc = {2'b00, sub_len(beat.pad_byte[7:5])};
                    end
                    if (beat.pad_byte[4:0] != 5'd0)
                    begin
                        tbl_we         = 1'b1;
                        ind_count_next = cnt_inc;
                        len_acc_next   = acc_inc;
                        if (cnt_inc == IND_CNT_W'(MAX_INDICATORS))
                        begin
                            stored_len_next = acc_inc + 8'(MAX_INDICATORS);
                            ind_pos_next    = '0;
                            sub_count_next  = '0;
                            phase_next      = PH_CONT;
                        end
                    end
                    else
                    begin
                        // End marker counts as one byte of the field
                        stored_len_next = len_acc_next + 8'(ind_count_next) + 8'd1;
                        ind_pos_next    = '0;
                        sub_count_next  = '0;
                        phase_next      = (ind_count_next == '0) ? PH_IDLE : PH_CONT;
                    end
                end
                PH_CONT:
                begin
                    if (t == APP_LENGTH)
                    begin
                        if (sub_count_reg == 6'd0)
                        begin
                            len_high_next  = beat.pad_byte[5:0];
                            prev_type_next = APP_LENGTH;
                        end
                        else if (sub_count_reg == 6'd1)
                        begin
                            group_len_next    = {len_high_reg, beat.pad_byte};
                            emit              = 1'b1;
                            res.app_type      = APP_LENGTH;
                            res.length_strobe = 1'b1;
                        end
                        sub_count_next = sub_count_reg + 6'd1;
                        last           = (sub_count_next >= LEN_SUB_BYTES);
                    end
                    else if (t == APP_LABEL || t == APP_LABEL_CONT
                             || t == APP_MOT_START || t == APP_MOT_CONT)
                    begin
                        last = ({1'b0, sub_count_reg} + 7'd1) >= {1'b0, len};
                        if (sub_count_reg == 6'd0)
                        begin
                            prev_type_next = t;
                            if (t == APP_MOT_START)
                            begin
                                group_open_next = {8'd0, len} < group_len_reg;
                            end
                        end
                        emit           = 1'b1;
                        res.out_byte   = beat.pad_byte;
                        res.app_type   = t;
                        res.sub_first  = (sub_count_reg == 6'd0);
                        res.sub_last   = last;
                        sub_count_next = sub_count_reg + 6'd1;
                    end
                    else
                    begin
                        // Unknown type: drop the rest of the field
                        phase_next = PH_IDLE;
                    end
                    if (last)
                    begin
                        sub_count_next = '0;
                        if (({1'b0, ind_pos_reg} + 1'b1) >= ind_count_reg)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            ind_pos_next = ind_pos_reg + 1'b1;
                        end
                    end
                end
                PH_REPLAY:
                begin
                    last           = ({1'b0, field_pos_next} + 9'd1) >= {1'b0, stored_len_reg};
                    emit           = 1'b1;
                    res.out_byte   = beat.pad_byte;
                    res.app_type   = lab ? APP_LABEL_CONT : APP_MOT_CONT;
                    res.sub_first  = (field_pos_next == 8'd0);
                    res.sub_last   = last;
                    res.without_ci = 1'b1;
                    if (last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            pos_inc        = field_pos_next + 8'd1;
            field_pos_next = pos_inc;
            if (pos_inc >= field_len_next || pos_inc == 8'd0)
            begin
                phase_next = PH_IDLE;
            end
        end

        res.group_length = group_len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            field_len_reg  <= '0;
            field_pos_reg  <= '0;
            ind_count_reg  <= '0;
            ind_pos_reg    <= '0;
            sub_count_reg  <= '0;
            stored_len_reg <= '0;
            len_acc_reg    <= '0;
            prev_type_reg  <= '0;
            group_len_reg  <= '0;
            len_high_reg   <= '0;
            group_open_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            field_len_reg  <= field_len_next;
            field_pos_reg  <= field_pos_next;
            ind_count_reg  <= ind_count_next;
            ind_pos_reg    <= ind_pos_next;
            sub_count_reg  <= sub_count_next;
            stored_len_reg <= stored_len_next;
            len_acc_reg    <= len_acc_next;
            prev_type_reg  <= prev_type_next;
            group_len_reg  <= group_len_next;
            len_high_reg   <= len_high_next;
            group_open_reg <= group_open_next;
        end
    end

    // Indicator store: slot picked by the count before this beat
    always_ff @(posedge clk)
    begin
        if (take && tbl_we)
        begin
            ind_table[ind_count_next[IND_IDX_W-1:0] - 1'b1] <= beat.pad_byte;
        end
    end

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        take && phase_reg == PH_IDLE && !beat.field_start |=> phase_reg == PH_IDLE)
        else $error("engine left idle without a field start");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CONT |-> {1'b0, ind_pos_reg} < ind_count_reg)
        else $error("subfield position beyond indicator count");

    a_replay_source: assert property (@(posedge clk) disable iff (!rst_n)
        emit && res.without_ci |-> phase_reg == PH_REPLAY || beat.field_start)
        else $error("replayed byte outside a replay field");

    a_strobe_type: assert property (@(posedge clk) disable iff (!rst_n)
        emit && res.length_strobe |-> res.app_type == APP_LENGTH && !res.sub_first
        && !res.sub_last)
        else $error("length result with data marks");

endmodule
`default_nettype wire

### rtl/xfd_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// X-PAD field demultiplexer output stage
// Result register; holds a stalled beat and tells the engine when it may move.
// ----------------------------------------------------------------------------
module xfd_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             held_valid,
    input  wire logic             emit,
    input  wire xfd_pkg::result_t res,
    output logic                  take,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output xfd_pkg::result_t      res_out
);
    import xfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    logic    room;

    assign room       = !valid_reg || !out_stall;
    assign take       = held_valid && room;
    assign valid_next = take ? emit : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule
`default_nettype wire

### rtl/xpad_field_demultiplexer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// X-PAD field demultiplexer
// Splits a variable X-PAD field into tagged subfield bytes and group lengths.
// ----------------------------------------------------------------------------
// Takes one X-PAD byte per cycle with its F-PAD pair and gives at most one
// result per byte: the input register loads the accepted byte, then the
// engine takes it and the field state update goes into the result register.
// The whole field state advances once per accepted beat, so the sustained
// rate is one byte per cycle while out_stall is low. A result waiting under
// out_stall blocks the engine; the input register still takes one more beat.
// Indicator bytes, the silent bytes of a length subfield and dropped bytes
// give no result.
// ----------------------------------------------------------------------------
module xpad_field_demultiplexer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  pad_byte,
    input  wire logic        field_start,
    input  wire logic [7:0]  field_bytes,
    input  wire logic [7:0]  fpad_high,
    input  wire logic [7:0]  fpad_low,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic [4:0]       app_type,
    output logic             sub_first,
    output logic             sub_last,
    output logic             without_ci,
    output logic [13:0]      group_length,
    output logic             length_strobe
);
    import xfd_pkg::*;

    in_beat_t beat_in;
    in_beat_t held_beat;
    logic     held_valid;
    logic     take;
    logic     emit;
    result_t  res;
    result_t  res_out;

    assign beat_in.pad_byte    = pad_byte;
    assign beat_in.field_start = field_start;
    assign beat_in.field_bytes = field_bytes;
    assign beat_in.fpad_high   = fpad_high;
    assign beat_in.fpad_low    = fpad_low;

    xfd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .beat_in    (beat_in),
        .take       (take),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    xfd_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .beat  (held_beat),
        .emit  (emit),
        .res   (res)
    );

    xfd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .emit       (emit),
        .res        (res),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .res_out    (res_out)
    );

    assign out_byte      = res_out.out_byte;
    assign app_type      = res_out.app_type;
    assign sub_first     = res_out.sub_first;
    assign sub_last      = res_out.sub_last;
    assign without_ci    = res_out.without_ci;
    assign group_length  = res_out.group_length;
    assign length_strobe = res_out.length_strobe;

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// X-PAD field demultiplexer testbench
// Drives F-PAD pairs and X-PAD byte streams into the demultiplexer: a short
// directed set of fields, then random fields with contents indicators,
// continuation replays, truncated or unhandled fields and loose noise beats.
// A tagger in the bench predicts every result beat, and each
// result beat taken from the block is compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
    import xfd_pkg::*;

    localparam logic [7:0]  CI_FLAG      = 8'h02;
    localparam int unsigned RANDOM_BEATS = 1800;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_INDICATORS,
        FS_SUBFIELDS,
        FS_REPLAY
    } field_state_t;

    // Tracks the field state beat by beat and holds the tagged bytes still due
    class subfield_tagger;
        field_state_t fstate;
        logic [7:0]   ind_tab[MAX_INDICATORS];
        int unsigned  ind_count;
        int unsigned  ind_pos;
        int unsigned  sub_cnt;
        logic [7:0]   stored_len;
        logic [4:0]   prev_type;
        logic [13:0]  grp_len;
        logic [5:0]   len_hi;
        bit           grp_open;
        logic [7:0]   fld_len;
        logic [7:0]   fld_pos;
        int unsigned  sub_len_tab[8];
        result_t      tagged_q[$];
        int unsigned  fails;

        function new();
            sub_len_tab = '{4, 6, 8, 12, 16, 24, 32, 48};
            foreach (ind_tab[i]) ind_tab[i] = 8'd0;
            fstate     = FS_IDLE;
            ind_count  = 0;
            ind_pos    = 0;
            sub_cnt    = 0;
            stored_len = 8'd0;
            prev_type  = 5'd0;
            grp_len    = 14'd0;
            len_hi     = 6'd0;
            grp_open   = 1'b0;
            fld_len    = 8'd0;
            fld_pos    = 8'd0;
            fails      = 0;
        endfunction

        function void push_tag(logic [7:0] b, logic [4:0] t, bit first, bit last,
                               bit noci, bit strobe);
            result_t r;
            r.out_byte      = b;
            r.app_type      = t;
            r.sub_first     = first;
            r.sub_last      = last;
            r.without_ci    = noci;
            r.group_length  = grp_len;
            r.length_strobe = strobe;
            tagged_q.insert(tagged_q.size(), r);
        endfunction

        // Field length is the subfield sum plus the indicator bytes and end marker, if any
        function void close_indicators();
            int unsigned sum;
            sum = 0;
            for (int i = 0; i < ind_count; i++)
                sum += sub_len_tab[ind_tab[i][7:5]];
            sum += (ind_count >= MAX_INDICATORS) ? ind_count : ind_count + 1;
            stored_len = 8'(sum);
            ind_pos    = 0;
            sub_cnt    = 0;
            fstate     = (ind_count == 0) ? FS_IDLE : FS_SUBFIELDS;
        endfunction

        function void advance_subfield();
            sub_cnt = 0;
            if (ind_pos + 1 >= ind_count)
                fstate = FS_IDLE;
            else
                ind_pos++;
        endfunction

        // Returns 1 when the beat is taken into a live field
        function bit take_pad_byte(in_beat_t beat);
            logic [7:0]  ind;
            logic [4:0]  t;
            int unsigned len;
            bit          first;
            bit          last;
            bit          lab;
            bit          mot;
            if (beat.field_start)
            begin
                fld_len = beat.field_bytes;
                fld_pos = 8'd0;
                fstate  = FS_IDLE;
                if (fld_len != 0 && beat.fpad_high[7:6] == FPAD_TYPE_0
                    && beat.fpad_high[5:4] == XPAD_IND_VAR)
                begin
                    if ((beat.fpad_low & CI_FLAG) != 0)
                    begin
                        ind_count = 0;
                        fstate    = FS_INDICATORS;
                    end
                    else
                    begin
                        lab = prev_type == APP_LABEL || prev_type == APP_LABEL_CONT;
                        mot = (prev_type == APP_MOT_START || prev_type == APP_MOT_CONT)
                              && grp_open;
                        if (stored_len != 0 && fld_len >= stored_len && (lab || mot))
                            fstate = FS_REPLAY;
                    end
                end
            end
            if (fstate == FS_IDLE)
                return 1'b0;

            case (fstate)
                FS_INDICATORS:
                begin
                    if (beat.pad_byte[4:0] != 5'd0 && ind_count < MAX_INDICATORS)
                    begin
                        ind_tab[ind_count] = beat.pad_byte;
                        ind_count++;
                        if (ind_count >= MAX_INDICATORS)
                            close_indicators();
                    end
                    else
                        close_indicators();
                end
                FS_SUBFIELDS:
                begin
                    ind = ind_tab[ind_pos];
                    t   = ind[4:0];
                    len = sub_len_tab[ind[7:5]];
                    if (t == APP_LENGTH)
                    begin
                        if (sub_cnt == 0)
                        begin
                            len_hi    = beat.pad_byte[5:0];
                            prev_type = APP_LENGTH;
                        end
                        else if (sub_cnt == 1)
                        begin
                            grp_len = {len_hi, beat.pad_byte};
                            push_tag(8'd0, APP_LENGTH, 1'b0, 1'b0, 1'b0, 1'b1);
                        end
                        sub_cnt++;
                        if (sub_cnt >= LEN_SUB_BYTES)
                            advance_subfield();
                    end
                    else if (t == APP_LABEL || t == APP_LABEL_CONT
                             || t == APP_MOT_START || t == APP_MOT_CONT)
                    begin
                        first = sub_cnt == 0;
                        last  = sub_cnt + 1 >= len;
                        if (first)
                        begin
                            prev_type = t;
                            if (t == APP_MOT_START)
                                grp_open = len < grp_len;
                        end
                        push_tag(beat.pad_byte, t, first, last, 1'b0, 1'b0);
                        sub_cnt++;
                        if (last)
                            advance_subfield();
                    end
                    else
                        fstate = FS_IDLE;  // unknown type: drop the rest
                end
                FS_REPLAY:
                begin
                    t = (prev_type == APP_LABEL || prev_type == APP_LABEL_CONT)
                        ? APP_LABEL_CONT : APP_MOT_CONT;
                    last = (fld_pos + 9'd1) >= stored_len;
                    push_tag(beat.pad_byte, t, fld_pos == 8'd0, last, 1'b1, 1'b0);
                    if (last)
                        fstate = FS_IDLE;
                end
                default: ;
            endcase

            fld_pos = fld_pos + 8'd1;
            if (fld_pos >= fld_len || fld_pos == 8'd0)
                fstate = FS_IDLE;
            return 1'b1;
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                fails++;
            end
        endfunction

        function void match_tagged(result_t got);
            result_t want;
            if (tagged_q.size() == 0)
            begin
                $error("result beat with nothing pending: byte %0d, type %0d",
                       got.out_byte, got.app_type);
                fails++;
                return;
            end
            want = tagged_q.pop_front();
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("app_type", want.app_type, got.app_type);
            check_field("sub_first", want.sub_first, got.sub_first);
            check_field("sub_last", want.sub_last, got.sub_last);
            check_field("without_ci", want.without_ci, got.without_ci);
            check_field("group_length", want.group_length, got.group_length);
            check_field("length_strobe", want.length_strobe, got.length_strobe);
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [7:0]  pad_byte      = 8'd0;
    logic        field_start   = 1'b0;
    logic [7:0]  field_bytes   = 8'd0;
    logic [7:0]  fpad_high     = 8'd0;
    logic [7:0]  fpad_low      = 8'd0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [7:0]  out_byte;
    logic [4:0]  app_type;
    logic        sub_first;
    logic        sub_last;
    logic        without_ci;
    logic [13:0] group_length;
    logic        length_strobe;

    subfield_tagger tagger = new();
    bit             idle_on = 1'b1;
    int unsigned    sent    = 0;
    int unsigned    cycles  = 0;

    xpad_field_demultiplexer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pad_byte      (pad_byte),
        .field_start   (field_start),
        .field_bytes   (field_bytes),
        .fpad_high     (fpad_high),
        .fpad_low      (fpad_low),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .app_type      (app_type),
        .sub_first     (sub_first),
        .sub_last      (sub_last),
        .without_ci    (without_ci),
        .group_length  (group_length),
        .length_strobe (length_strobe)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= idle_on && ($urandom_range(99) < 6);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tagger.match_tagged(result_t'({out_byte, app_type, sub_first, sub_last,
                                           without_ci, group_length, length_strobe}));
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("xpad_field_demultiplexer_top verification failed");
            $finish;
        end
    end

    // Offer one beat from a falling edge and hold it until it is taken
    task automatic send_beat(input logic [7:0] pb, input logic start,
                             input logic [7:0] fb, input logic [7:0] hi,
                             input logic [7:0] lo);
        in_beat_t beat;
        beat = {pb, start, fb, hi, lo};
        while (idle_on && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        pad_byte    <= pb;
        field_start <= start;
        field_bytes <= fb;
        fpad_high   <= hi;
        fpad_low    <= lo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        void'(tagger.take_pad_byte(beat));
        sent++;
        @(negedge clk);
    endtask

    // F-PAD and length count only matter on the first beat; scramble them after
    task automatic send_field(input logic [7:0] hi, input logic [7:0] lo,
                              input logic [7:0] fb, input logic [7:0] data_q[$],
                              input int unsigned n_send);
        for (int i = 0; i < n_send && i < data_q.size(); i++)
        begin
            if (i == 0)
                send_beat(data_q[i], 1'b1, fb, hi, lo);
            else
                send_beat(data_q[i], 1'b0, 8'($urandom_range(1, 255)), 8'($urandom),
                          8'($urandom));
        end
    endtask

    task automatic send_indicator_field(input bit broken);
        logic [7:0]  inds[$];
        logic [7:0]  data_q[$];
        logic [4:0]  t;
        logic [2:0]  code;
        logic [7:0]  hi;
        int unsigned n_ind;
        int unsigned total;
        int unsigned fb;
        int unsigned n_send;
        int unsigned r;
        n_ind = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, MAX_INDICATORS);
        for (int i = 0; i < n_ind; i++)
        begin
            r = $urandom_range(99);
            if (r < 20)
                t = APP_LENGTH;
            else if (r < 40)
                t = APP_LABEL;
            else if (r < 55)
                t = APP_LABEL_CONT;
            else if (r < 75)
                t = APP_MOT_START;
            else if (r < 93)
                t = APP_MOT_CONT;
            else
                t = 5'($urandom_range(1, 31));
            // keep subfields short most of the time
            if (t == APP_LENGTH && $urandom_range(9) != 0)
                code = 3'd0;
            else if ($urandom_range(99) < 75)
                code = 3'($urandom_range(3));
            else
                code = 3'($urandom);
            inds.insert(inds.size(), {code, t});
            data_q.insert(data_q.size(), {code, t});
        end
        if (n_ind < MAX_INDICATORS)
            data_q.insert(data_q.size(), {3'($urandom), 5'd0});
        foreach (inds[i])
        begin
            if (inds[i][4:0] == APP_LENGTH)
            begin
                data_q.insert(data_q.size(),
                              $urandom_range(1) ? {2'($urandom), 6'd0} : 8'($urandom));
                repeat (3) data_q.insert(data_q.size(), 8'($urandom));
            end
            else
                repeat (tagger.sub_len_tab[inds[i][7:5]])
                    data_q.insert(data_q.size(), 8'($urandom));
        end
        total = data_q.size();
        hi    = {FPAD_TYPE_0, XPAD_IND_VAR, 4'($urandom)};
        if (broken)
        begin
            if ($urandom_range(2) == 0)
                hi = 8'($urandom);
            fb     = $urandom_range(1, total);
            n_send = $urandom_range(1, total);
        end
        else
        begin
            fb     = ($urandom_range(3) == 0) ? $urandom_range(total + 1, 255) : total;
            n_send = total;
        end
        send_field(hi, 8'($urandom) | CI_FLAG, 8'(fb), data_q, n_send);
    endtask

    task automatic send_replay_field();
        logic [7:0]  data_q[$];
        int unsigned sl;
        int unsigned fb;
        int unsigned n_send;
        sl = tagger.stored_len;
        if (sl != 0 && $urandom_range(99) < 85)
            fb = sl + $urandom_range(0, (255 - sl < 3) ? 255 - sl : 3);
        else
            fb = $urandom_range(1, 255);
        n_send = (sl == 0) ? 1 + $urandom_range(2) : sl + $urandom_range(1);
        if (n_send > fb)
            n_send = fb;
        repeat (n_send) data_q.insert(data_q.size(), 8'($urandom));
        send_field({FPAD_TYPE_0, XPAD_IND_VAR, 4'($urandom)}, 8'($urandom) & ~CI_FLAG,
                   8'(fb), data_q, n_send);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_beat(8'($urandom), $urandom_range(3) == 0, 8'($urandom_range(1, 255)),
                      $urandom_range(1) ? {FPAD_TYPE_0, XPAD_IND_VAR, 4'($urandom)}
                                        : 8'($urandom),
                      8'($urandom));
    endtask

    initial
    begin
        logic [7:0]  data_q[$];
        int unsigned r;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Length subfield at full scale, then a MOT start that opens a group
        data_q = '{{3'd0, APP_LENGTH}, {3'd0, APP_MOT_START}, 8'hE0,
                   8'hFF, 8'hFF, 8'h00, 8'h00,
                   8'h00, 8'hFF, 8'h55, 8'hAA};
        send_field({FPAD_TYPE_0, XPAD_IND_VAR, 4'hF}, CI_FLAG, 8'd11, data_q, 11);
        // Continuation without indicators in the widest field
        data_q = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h10, 8'h20, 8'h40,
                   8'h08, 8'hC3};
        send_field({FPAD_TYPE_0, XPAD_IND_VAR, 4'h0}, 8'hFD, 8'hFF, data_q, 11);
        // Unhandled F-PAD type, single-byte field
        data_q = '{8'h5A};
        send_field(8'hFF, CI_FLAG, 8'd1, data_q, 1);
        // Unknown application type drops the remainder
        data_q = '{8'hFF, 8'h00, 8'h5A};
        send_field({FPAD_TYPE_0, XPAD_IND_VAR, 4'h5}, 8'hFF, 8'd3, data_q, 3);

        while (sent < RANDOM_BEATS)
        begin
            // one long stretch without gaps or stalls
            idle_on = !(sent >= 700 && sent < 1000);
            r = $urandom_range(99);
            if (r < 55)
                send_indicator_field(1'b0);
            else if (r < 80)
                send_replay_field();
            else if (r < 92)
                send_indicator_field(1'b1);
            else
                send_noise();
        end
        in_valid <= 1'b0;

        while (tagger.tagged_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tagger.fails == 0 && tagger.tagged_q.size() == 0)
            $display("xpad_field_demultiplexer_top verification clean");
        else
            $display("xpad_field_demultiplexer_top verification failed");
        $finish;
    end

endmodule

### files.f
rtl/xfd_pkg.sv
rtl/xfd_in_stage.sv
rtl/xfd_engine.sv
rtl/xfd_out_stage.sv
rtl/xpad_field_demultiplexer_top.sv
sim/tb.sv
